// File: src/rtnh_pkg.sv
// shared types, constants and helper functions for the ray/triangle nearest-hit core
package rtnh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int TLIM_W    = 31;
  localparam int PROD_W    = 2 * COORD_W - FRAC_BITS;
  localparam int ACC_W     = PROD_W + 2;
  localparam int NUM_W     = ACC_W + 1;
  localparam int REM_W     = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_T_LIMIT  = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    coord_t              origin_x;
    coord_t              origin_y;
    coord_t              origin_z;
    coord_t              dir_x;
    coord_t              dir_y;
    coord_t              dir_z;
    logic [TLIM_W-1:0]   t_limit;
  } cfg_t;

  // whole-vector operations
  typedef enum logic [2:0] {
    VOP_NONE,
    VOP_SETUP,
    VOP_W_OA,
    VOP_W_QA,
    VOP_EDGE0,
    VOP_EDGE1,
    VOP_EDGE2
  } vop_t;

  // multiplier operand pairings
  typedef enum logic [2:0] {
    MS_NONE,
    MS_CROSS_EW,
    MS_CROSS_NE,
    MS_DOT_WN,
    MS_DOT_KW,
    MS_DIR_T,
    MS_DIR_BEST
  } msrc_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_N,
    ST_K,
    ST_D1,
    ST_D2,
    ST_P,
    ST_EDGE
  } st_t;

  typedef struct packed {
    logic     load;
    vop_t     vop;
    msrc_t    msrc;
    logic [2:0] cnt;
    acc_op_t  acc_op;
    st_t      st;
    logic     div_start;
    logic     best_upd;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic opposite;
    logic div_done;
    logic t_in_limit;
    logic last;
    logic out_busy;
  } stat_t;

  // cross product operand components, two products per result component
  function automatic logic [1:0] cross_u(input logic [2:0] cnt);
    logic [1:0] r;
    unique case (cnt)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_v(input logic [2:0] cnt);
    logic [1:0] r;
    unique case (cnt)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic coord_t sat_acc(input logic signed [ACC_W-1:0] x);
    coord_t r;
    if ((&x[ACC_W-1:COORD_W-1]) || !(|x[ACC_W-1:COORD_W-1])) begin
      r = x[COORD_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic coord_t sat_sub(input coord_t x, input coord_t y);
    logic signed [COORD_W:0] d;
    coord_t r;
    d = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    if (d[COORD_W] == d[COORD_W-1]) begin
      r = d[COORD_W-1:0];
    end else if (d[COORD_W]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic coord_t sat_add(input coord_t x, input coord_t y);
    logic signed [COORD_W:0] d;
    coord_t r;
    d = {x[COORD_W-1], x} + {y[COORD_W-1], y};
    if (d[COORD_W] == d[COORD_W-1]) begin
      r = d[COORD_W-1:0];
    end else if (d[COORD_W]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: src/ray_triangle_nearest_hit_core.sv
// Nearest ray/triangle hit over a triangle stream, Q16.16 fixed point. Each triangle request
// runs through one shared 32x32 multiplier (one product a cycle, pipelined into an
// accumulator) and, once past the plane test, a restoring divider giving one bit of t a
// cycle. A triangle that reaches the edge tests takes 42 products and FRAC_BITS divider
// steps, and the last triangle also forms the hit point. The result register lets a new
// triangle be taken while a result still waits. Ray registers must be written only while
// the block is idle.
module ray_triangle_nearest_hit_core import rtnh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  coord_t            in_a_x,
  input  coord_t            in_a_y,
  input  coord_t            in_a_z,
  input  coord_t            in_b_x,
  input  coord_t            in_b_y,
  input  coord_t            in_b_z,
  input  coord_t            in_c_x,
  input  coord_t            in_c_y,
  input  coord_t            in_c_z,
  input  logic              in_last_triangle,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [TLIM_W-1:0] out_distance,
  output coord_t            out_point_x,
  output coord_t            out_point_y,
  output coord_t            out_point_z
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  rtnh_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rtnh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtnh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_a_x           (in_a_x),
    .in_a_y           (in_a_y),
    .in_a_z           (in_a_z),
    .in_b_x           (in_b_x),
    .in_b_y           (in_b_y),
    .in_b_z           (in_b_z),
    .in_c_x           (in_c_x),
    .in_c_y           (in_c_y),
    .in_c_z           (in_c_z),
    .in_last_triangle (in_last_triangle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_distance     (out_distance),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z)
  );

endmodule

// File: src/rtnh_regs.sv
// apb configuration registers: ray origin, direction and distance limit
module rtnh_regs import rtnh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.origin_z <= '0;
      cfg_r.dir_x    <= '0;
      cfg_r.dir_y    <= '0;
      cfg_r.dir_z    <= '0;
      cfg_r.t_limit  <= '1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ORIGIN_X: cfg_r.origin_x <= pwdata;
        REG_ORIGIN_Y: cfg_r.origin_y <= pwdata;
        REG_ORIGIN_Z: cfg_r.origin_z <= pwdata;
        REG_DIR_X:    cfg_r.dir_x    <= pwdata;
        REG_DIR_Y:    cfg_r.dir_y    <= pwdata;
        REG_DIR_Z:    cfg_r.dir_z    <= pwdata;
        REG_T_LIMIT:  cfg_r.t_limit  <= pwdata[TLIM_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = cfg_r.origin_x;
      REG_ORIGIN_Y: prdata = cfg_r.origin_y;
      REG_ORIGIN_Z: prdata = cfg_r.origin_z;
      REG_DIR_X:    prdata = cfg_r.dir_x;
      REG_DIR_Y:    prdata = cfg_r.dir_y;
      REG_DIR_Z:    prdata = cfg_r.dir_z;
      REG_T_LIMIT:  prdata = {{(DATA_W-TLIM_W){1'b0}}, cfg_r.t_limit};
      default:      prdata = '0;
    endcase
  end

endmodule

// File: src/rtnh_dp.sv
// datapath: vector registers, shared multiplier, accumulator, divider, best-hit and output
module rtnh_dp import rtnh_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  output stat_t  stat,
  input  coord_t in_a_x,
  input  coord_t in_a_y,
  input  coord_t in_a_z,
  input  coord_t in_b_x,
  input  coord_t in_b_y,
  input  coord_t in_b_z,
  input  coord_t in_c_x,
  input  coord_t in_c_y,
  input  coord_t in_c_z,
  input  logic   in_last_triangle,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_hit,
  output logic [TLIM_W-1:0] out_distance,
  output coord_t out_point_x,
  output coord_t out_point_y,
  output coord_t out_point_z
);

  coord_t a_r [3];
  coord_t b_r [3];
  coord_t c_r [3];
  coord_t e_r [3];
  coord_t w_r [3];
  coord_t n_r [3];
  coord_t k_r [3];
  coord_t p_r [3];
  coord_t org [3];
  coord_t dir [3];
  logic   last_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  acc_op_t                  acc_op_s_r;
  st_t                      st_s_r;
  logic [2:0]               cnt_s_r;

  logic signed [ACC_W-1:0] d1_r;
  logic signed [ACC_W-1:0] d2_r;

  logic [REM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     den_r;
  logic [FRAC_BITS-1:0] t_r;
  logic                 div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [REM_W-1:0]     rem_sh;
  logic [NUM_W-1:0]     num_abs;
  logic [NUM_W-1:0]     d2_abs;

  logic               inside_r;
  logic [COORD_W-1:0] best_t_r;
  logic               found_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [TLIM_W-1:0]  out_distance_r;
  coord_t             out_point_x_r;
  coord_t             out_point_y_r;
  coord_t             out_point_z_r;

  coord_t                 mul_a;
  coord_t                 mul_b;
  logic signed [2*COORD_W-1:0] mul_full;
  logic [1:0]             ui;
  logic [1:0]             vi;
  logic [1:0]             di;
  logic [1:0]             si;
  logic signed [ACC_W-1:0] pt_sum;

  assign org[0] = cfg.origin_x;
  assign org[1] = cfg.origin_y;
  assign org[2] = cfg.origin_z;
  assign dir[0] = cfg.dir_x;
  assign dir[1] = cfg.dir_y;
  assign dir[2] = cfg.dir_z;

  assign ui = cross_u(cmd.cnt);
  assign vi = cross_v(cmd.cnt);
  assign di = cmd.cnt[1:0];

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.msrc)
      MS_CROSS_EW: begin mul_a = e_r[ui]; mul_b = w_r[vi]; end
      MS_CROSS_NE: begin mul_a = n_r[ui]; mul_b = e_r[vi]; end
      MS_DOT_WN:   begin mul_a = w_r[di]; mul_b = n_r[di]; end
      MS_DOT_KW:   begin mul_a = k_r[di]; mul_b = w_r[di]; end
      MS_DIR_T:    begin mul_a = dir[di]; mul_b = {{(COORD_W-FRAC_BITS){1'b0}}, t_r}; end
      MS_DIR_BEST: begin mul_a = dir[di]; mul_b = best_t_r; end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_full = (2*COORD_W)'(mul_a) * (2*COORD_W)'(mul_b);
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    unique case (acc_op_s_r)
      ACC_LOAD: acc_nxt = prod_ext;
      ACC_ADD:  acc_nxt = acc_r + prod_ext;
      ACC_SUB:  acc_nxt = acc_r - prod_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  assign si     = cnt_s_r[1:0];
  assign pt_sum = {{(ACC_W-COORD_W){org[si][COORD_W-1]}}, org[si]} + prod_ext;

  // multiply stage and accumulate/store stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_s_r <= ACC_NONE;
      st_s_r     <= ST_NONE;
    end else begin
      acc_op_s_r <= cmd.acc_op;
      st_s_r     <= cmd.st;
    end
    cnt_s_r <= cmd.cnt;
    prod_r  <= PROD_W'(mul_full >>> FRAC_BITS);
    acc_r   <= acc_nxt;
    unique case (st_s_r)
      ST_N:    n_r[cnt_s_r[2:1]] <= sat_acc(acc_nxt);
      ST_K:    k_r[cnt_s_r[2:1]] <= sat_acc(acc_nxt);
      ST_D1:   d1_r <= acc_nxt;
      ST_D2:   d2_r <= acc_nxt;
      ST_P:    p_r[si] <= sat_acc(pt_sum);
      default: ;
    endcase
  end

  // triangle capture and whole-vector differences
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r[0] <= in_a_x; a_r[1] <= in_a_y; a_r[2] <= in_a_z;
      b_r[0] <= in_b_x; b_r[1] <= in_b_y; b_r[2] <= in_b_z;
      c_r[0] <= in_c_x; c_r[1] <= in_c_y; c_r[2] <= in_c_z;
      last_r <= in_last_triangle;
    end
    for (int i = 0; i < 3; i++) begin
      unique case (cmd.vop)
        VOP_SETUP: begin
          e_r[i] <= sat_sub(b_r[i], a_r[i]);
          w_r[i] <= sat_sub(c_r[i], a_r[i]);
        end
        VOP_W_OA: w_r[i] <= sat_sub(org[i], a_r[i]);
        VOP_W_QA: w_r[i] <= sat_sub(sat_add(org[i], dir[i]), a_r[i]);
        VOP_EDGE0: begin
          e_r[i] <= sat_sub(b_r[i], a_r[i]);
          w_r[i] <= sat_sub(p_r[i], a_r[i]);
        end
        VOP_EDGE1: begin
          e_r[i] <= sat_sub(c_r[i], b_r[i]);
          w_r[i] <= sat_sub(p_r[i], b_r[i]);
        end
        VOP_EDGE2: begin
          e_r[i] <= sat_sub(a_r[i], c_r[i]);
          w_r[i] <= sat_sub(p_r[i], a_r[i]);
        end
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit a cycle
  assign num_abs = d1_r[ACC_W-1] ? NUM_W'(-{d1_r[ACC_W-1], d1_r}) : NUM_W'({1'b0, d1_r});
  assign d2_abs  = d2_r[ACC_W-1] ? NUM_W'(-{d2_r[ACC_W-1], d2_r}) : NUM_W'({1'b0, d2_r});
  assign rem_sh  = {rem_r[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (div_cnt_r == DIV_CNT_W'(FRAC_BITS - 1)) begin
        div_busy_r <= 1'b0;
      end
    end
    if (cmd.div_start) begin
      rem_r <= {1'b0, num_abs};
      den_r <= num_abs + d2_abs;
      t_r   <= '0;
    end else if (div_busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        t_r   <= {t_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        t_r   <= {t_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // edge tests, running minimum and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      best_t_r    <= '1;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        inside_r <= 1'b1;
      end else if (st_s_r == ST_EDGE && acc_nxt[ACC_W-1]) begin
        inside_r <= 1'b0;
      end
      if (cmd.best_upd && inside_r &&
          ({{(COORD_W-FRAC_BITS){1'b0}}, t_r} < best_t_r)) begin
        best_t_r <= {{(COORD_W-FRAC_BITS){1'b0}}, t_r};
        found_r  <= 1'b1;
      end
      if (cmd.emit) begin
        best_t_r    <= '1;
        found_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.emit) begin
      out_hit_r      <= found_r;
      out_distance_r <= found_r ? best_t_r[TLIM_W-1:0] : '0;
      out_point_x_r  <= found_r ? p_r[0] : '0;
      out_point_y_r  <= found_r ? p_r[1] : '0;
      out_point_z_r  <= found_r ? p_r[2] : '0;
    end
  end

  assign stat.opposite   = (d1_r[ACC_W-1] && !d2_r[ACC_W-1] && (d2_r != '0)) ||
                           (!d1_r[ACC_W-1] && (d1_r != '0) && d2_r[ACC_W-1]);
  assign stat.div_done   = div_busy_r && (div_cnt_r == DIV_CNT_W'(FRAC_BITS - 1));
  assign stat.t_in_limit = {{(TLIM_W-FRAC_BITS){1'b0}}, t_r} <= cfg.t_limit;
  assign stat.last       = last_r;
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;
  assign out_point_x  = out_point_x_r;
  assign out_point_y  = out_point_y_r;
  assign out_point_z  = out_point_z_r;

endmodule

// File: src/rtnh_ctrl.sv
// controller: sequences the per-triangle operations on the datapath
module rtnh_ctrl import rtnh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_CROSS_N, S_WOA, S_D1, S_WQA, S_D2, S_DRAIN, S_SIGN,
    S_DIV, S_LIM, S_PT, S_EV, S_CROSS_K, S_DK, S_BEST, S_NEXT, S_OPT, S_EMIT
  } state_t;

  state_t     state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] edge_r, edge_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cnt_nxt   = cnt_r;
    edge_nxt  = edge_r;
    cmd       = '{load: 1'b0, vop: VOP_NONE, msrc: MS_NONE, cnt: cnt_r,
                  acc_op: ACC_NONE, st: ST_NONE, div_start: 1'b0,
                  best_upd: 1'b0, emit: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.vop   = VOP_SETUP;
        cnt_nxt   = '0;
        state_nxt = S_CROSS_N;
      end
      S_CROSS_N: begin
        cmd.msrc   = MS_CROSS_EW;
        cmd.acc_op = cnt_r[0] ? ACC_SUB : ACC_LOAD;
        cmd.st     = cnt_r[0] ? ST_N : ST_NONE;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd5) state_nxt = S_WOA;
      end
      S_WOA: begin
        cmd.vop   = VOP_W_OA;
        cnt_nxt   = '0;
        state_nxt = S_D1;
      end
      S_D1: begin
        cmd.msrc   = MS_DOT_WN;
        cmd.acc_op = (cnt_r == 3'd0) ? ACC_LOAD : ACC_ADD;
        cmd.st     = (cnt_r == 3'd2) ? ST_D1 : ST_NONE;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd2) state_nxt = S_WQA;
      end
      S_WQA: begin
        cmd.vop   = VOP_W_QA;
        cnt_nxt   = '0;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.msrc   = MS_DOT_WN;
        cmd.acc_op = (cnt_r == 3'd0) ? ACC_LOAD : ACC_ADD;
        cmd.st     = (cnt_r == 3'd2) ? ST_D2 : ST_NONE;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_DRAIN;
          ret_nxt   = S_SIGN;
        end
      end
      S_DRAIN: begin
        // last accumulate of the previous run lands here
        cnt_nxt   = '0;
        state_nxt = ret_r;
      end
      S_SIGN: begin
        if (stat.opposite) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_LIM;
      end
      S_LIM: begin
        cnt_nxt   = '0;
        edge_nxt  = '0;
        state_nxt = stat.t_in_limit ? S_PT : S_NEXT;
      end
      S_PT: begin
        cmd.msrc = MS_DIR_T;
        cmd.st   = ST_P;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_DRAIN;
          ret_nxt   = S_EV;
        end
      end
      S_EV: begin
        unique case (edge_r)
          2'd0:    cmd.vop = VOP_EDGE0;
          2'd1:    cmd.vop = VOP_EDGE1;
          default: cmd.vop = VOP_EDGE2;
        endcase
        cnt_nxt   = '0;
        state_nxt = S_CROSS_K;
      end
      S_CROSS_K: begin
        cmd.msrc   = MS_CROSS_NE;
        cmd.acc_op = cnt_r[0] ? ACC_SUB : ACC_LOAD;
        cmd.st     = cnt_r[0] ? ST_K : ST_NONE;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          state_nxt = S_DRAIN;
          ret_nxt   = S_DK;
        end
      end
      S_DK: begin
        cmd.msrc   = MS_DOT_KW;
        cmd.acc_op = (cnt_r == 3'd0) ? ACC_LOAD : ACC_ADD;
        cmd.st     = (cnt_r == 3'd2) ? ST_EDGE : ST_NONE;
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_DRAIN;
          if (edge_r == 2'd2) begin
            ret_nxt = S_BEST;
          end else begin
            ret_nxt  = S_EV;
            edge_nxt = edge_r + 2'd1;
          end
        end
      end
      S_BEST: begin
        cmd.best_upd = 1'b1;
        state_nxt    = S_NEXT;
      end
      S_NEXT: begin
        cnt_nxt   = '0;
        state_nxt = stat.last ? S_OPT : S_IDLE;
      end
      S_OPT: begin
        cmd.msrc = MS_DIR_BEST;
        cmd.st   = ST_P;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = S_DRAIN;
          ret_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= '0;
      edge_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      edge_r  <= edge_nxt;
    end
  end

endmodule

// File: sim/rtnh_hit_checker.sv
// checker for the ray/triangle nearest-hit core: watches the ports, predicts and compares
module rtnh_hit_checker import rtnh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  coord_t            in_a_x,
  input  coord_t            in_a_y,
  input  coord_t            in_a_z,
  input  coord_t            in_b_x,
  input  coord_t            in_b_y,
  input  coord_t            in_b_z,
  input  coord_t            in_c_x,
  input  coord_t            in_c_y,
  input  coord_t            in_c_z,
  input  logic              in_last_triangle,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_hit,
  input  logic [TLIM_W-1:0] out_distance,
  input  coord_t            out_point_x,
  input  coord_t            out_point_y,
  input  coord_t            out_point_z,
  output int                fail_count,
  output int                pending_hits
);

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  typedef struct {
    logic              hit;
    logic [TLIM_W-1:0] distance;
    coord_t            px;
    coord_t            py;
    coord_t            pz;
  } hit_result_t;

  hit_result_t hit_results_q[$];

  vec3_t             ray_org;
  vec3_t             ray_dir;
  logic [TLIM_W-1:0] t_max;
  longint            nearest_t;
  logic              nearest_found;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // exact product, floored back to Q16.16
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic vec3_t vdiff(vec3_t u, vec3_t v);
    vec3_t r;
    r.x = sat32(u.x - v.x);
    r.y = sat32(u.y - v.y);
    r.z = sat32(u.z - v.z);
    return r;
  endfunction

  function automatic vec3_t vcross(vec3_t u, vec3_t v);
    vec3_t r;
    r.x = sat32(qmul(u.y, v.z) - qmul(u.z, v.y));
    r.y = sat32(qmul(u.z, v.x) - qmul(u.x, v.z));
    r.z = sat32(qmul(u.x, v.y) - qmul(u.y, v.x));
    return r;
  endfunction

  function automatic longint vdot(vec3_t u, vec3_t v);
    return qmul(u.x, v.x) + qmul(u.y, v.y) + qmul(u.z, v.z);
  endfunction

  function automatic vec3_t point_on_ray(longint t);
    vec3_t r;
    r.x = sat32(ray_org.x + qmul(ray_dir.x, t));
    r.y = sat32(ray_org.y + qmul(ray_dir.y, t));
    r.z = sat32(ray_org.z + qmul(ray_dir.z, t));
    return r;
  endfunction

  function automatic bit inside_edge(vec3_t n, vec3_t from, vec3_t to, vec3_t anchor,
                                     vec3_t p);
    return vdot(vcross(n, vdiff(to, from)), vdiff(p, anchor)) >= 0;
  endfunction

  // one triangle: update the nearest hit, queue the result on the last one
  task automatic predict_triangle();
    vec3_t a, b, c, n, q, p;
    longint d1, d2, num, den, rem, t;
    hit_result_t res;
    a = '{in_a_x, in_a_y, in_a_z};
    b = '{in_b_x, in_b_y, in_b_z};
    c = '{in_c_x, in_c_y, in_c_z};
    q.x = sat32(ray_org.x + ray_dir.x);
    q.y = sat32(ray_org.y + ray_dir.y);
    q.z = sat32(ray_org.z + ray_dir.z);
    n = vcross(vdiff(b, a), vdiff(c, a));
    d1 = vdot(vdiff(ray_org, a), n);
    d2 = vdot(vdiff(q, a), n);
    if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) begin
      num = d1 < 0 ? -d1 : d1;
      den = num + (d2 < 0 ? -d2 : d2);
      rem = num;
      t = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= den) begin
          rem = rem - den;
          t = t | 1;
        end
      end
      if (t <= longint'(t_max)) begin
        p = point_on_ray(t);
        if (inside_edge(n, a, b, a, p) && inside_edge(n, b, c, b, p) &&
            inside_edge(n, c, a, a, p) && t < nearest_t) begin
          nearest_t = t;
          nearest_found = 1'b1;
        end
      end
    end
    if (in_last_triangle) begin
      res = '{1'b0, '0, '0, '0, '0};
      if (nearest_found) begin
        p = point_on_ray(nearest_t);
        res.hit = 1'b1;
        res.distance = nearest_t > 64'h7FFFFFFF ? 31'h7FFFFFFF : nearest_t[TLIM_W-1:0];
        res.px = p.x[31:0];
        res.py = p.y[31:0];
        res.pz = p.z[31:0];
      end
      hit_results_q.push_back(res);
      nearest_t = 64'hFFFFFFFF;
      nearest_found = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    hit_result_t want;
    if (!rst_n) begin
      ray_org = '{0, 0, 0};
      ray_dir = '{0, 0, 0};
      t_max = 31'h7FFFFFFF;
      nearest_t = 64'hFFFFFFFF;
      nearest_found = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_ORIGIN_X: ray_org.x = longint'(signed'(pwdata));
          REG_ORIGIN_Y: ray_org.y = longint'(signed'(pwdata));
          REG_ORIGIN_Z: ray_org.z = longint'(signed'(pwdata));
          REG_DIR_X:    ray_dir.x = longint'(signed'(pwdata));
          REG_DIR_Y:    ray_dir.y = longint'(signed'(pwdata));
          REG_DIR_Z:    ray_dir.z = longint'(signed'(pwdata));
          REG_T_LIMIT:  t_max = pwdata[TLIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_triangle();
      if (out_valid && out_ready) begin
        if (hit_results_q.size() == 0) begin
          report_mismatch("unexpected result", out_hit, 0);
        end else begin
          want = hit_results_q.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_distance !== want.distance)
            report_mismatch("distance", out_distance, want.distance);
          if (out_point_x !== want.px) report_mismatch("point_x", out_point_x, want.px);
          if (out_point_y !== want.py) report_mismatch("point_y", out_point_y, want.py);
          if (out_point_z !== want.pz) report_mismatch("point_z", out_point_z, want.pz);
        end
      end
    end
    pending_hits = hit_results_q.size();
  end

endmodule

// File: sim/ray_triangle_nearest_hit_core_tb.sv
// testbench top for the ray/triangle nearest-hit core: stimulus, ray setup and verdict
module ray_triangle_nearest_hit_core_tb;
  import rtnh_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic   last;
  } triangle_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  coord_t            in_a_x = '0, in_a_y = '0, in_a_z = '0;
  coord_t            in_b_x = '0, in_b_y = '0, in_b_z = '0;
  coord_t            in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic              in_last_triangle = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [TLIM_W-1:0] out_distance;
  coord_t            out_point_x, out_point_y, out_point_z;
  int                fail_count;
  int                pending_hits;

  int   cycles = 0;
  int   sink_stall = 0;
  bit   gaps_on = 1'b1;
  int   ray[6];

  ray_triangle_nearest_hit_core i_dut (.*);

  rtnh_hit_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ray_triangle_nearest_hit_core regression: fail");
      $finish;
    end
  end

  // result side backpressure, drawn per result
  always @(posedge clk) begin
    if (out_valid && out_ready) sink_stall = gaps_on ? $urandom_range(0, 9) : 0;
  end

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // idle point: all results back, then room for a non-last triangle still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_hits == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, int tlim);
    wait_idle();
    ray = '{ox, oy, oz, dx, dy, dz};
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_T_LIMIT, tlim);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_triangle(triangle_t tr);
    int gap;
    in_a_x <= tr.ax; in_a_y <= tr.ay; in_a_z <= tr.az;
    in_b_x <= tr.bx; in_b_y <= tr.by; in_b_z <= tr.bz;
    in_c_x <= tr.cx; in_c_y <= tr.cy; in_c_z <= tr.cz;
    in_last_triangle <= tr.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, bit last);
    triangle_t tr;
    tr = '{ax, ay, az, bx, by, bz, cx, cy, cz, last};
    return tr;
  endfunction

  function automatic int rnd_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // triangle centered on a point of the current segment, so it is usually hit
  function automatic triangle_t hit_tri(bit last);
    int f, px, py, pz, ux, uy, uz, vx, vy, vz, sp;
    f = $urandom_range(1, 65535);
    px = ray[0] + int'((longint'(ray[3]) * f) >>> 16);
    py = ray[1] + int'((longint'(ray[4]) * f) >>> 16);
    pz = ray[2] + int'((longint'(ray[5]) * f) >>> 16);
    sp = 1 << $urandom_range(14, 22);
    ux = rnd_span(sp); uy = rnd_span(sp); uz = rnd_span(sp);
    vx = rnd_span(sp); vy = rnd_span(sp); vz = rnd_span(sp);
    return make_tri(px + ux, py + uy, pz + uz, px + vx, py + vy, pz + vz,
                    px - ux - vx, py - uy - vy, pz - uz - vz, last);
  endfunction

  function automatic triangle_t noise_tri(bit last);
    return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, last);
  endfunction

  function automatic int rnd_coord();
    return $urandom_range(0, 3) == 0 ? int'($urandom) : rnd_span(1 << 22);
  endfunction

  localparam int ONE = 32'h0001_0000;
  localparam int IMAX = 32'h7FFF_FFFF;
  localparam int IMIN = 32'h8000_0000;

  initial begin
    int sent, mesh_len, phase_len, tl;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset ray has zero direction: nothing can be hit
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b1));

    set_ray(0, 0, -ONE, 0, 0, 2 * ONE, IMAX);
    // plane hit at t = 0.5, then an equal-t repeat, reversed winding, a miss
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b0));
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b0));
    send_triangle(make_tri(0, ONE, 0, ONE, -ONE, 0, -ONE, -ONE, 0, 1'b1));
    send_triangle(make_tri(9 * ONE, -ONE, 0, 11 * ONE, -ONE, 0, 10 * ONE, ONE, 0, 1'b1));
    // nearer plane after a farther one
    send_triangle(make_tri(-ONE, -ONE, ONE / 2, ONE, -ONE, ONE / 2, 0, ONE, ONE / 2, 1'b0));
    send_triangle(make_tri(-ONE, -ONE, -ONE / 2, ONE, -ONE, -ONE / 2, 0, ONE, -ONE / 2,
                           1'b1));
    // degenerate, parallel to the ray, and segment ending short of the plane
    send_triangle(make_tri(ONE, ONE, 0, ONE, ONE, 0, ONE, ONE, 0, 1'b0));
    send_triangle(make_tri(0, -ONE, -ONE, 0, ONE, -ONE, 0, 0, 5 * ONE, 1'b0));
    send_triangle(make_tri(-ONE, -ONE, 3 * ONE, ONE, -ONE, 3 * ONE, 0, ONE, 3 * ONE, 1'b1));
    // field extremes
    send_triangle(make_tri(IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, 1'b0));
    send_triangle(make_tri(IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, 1'b1));
    send_triangle(make_tri(IMIN, IMIN, 0, IMAX, IMIN, 0, 0, IMAX, 0, 1'b1));
    send_triangle(make_tri(IMIN, IMAX, IMIN, IMAX, IMIN, IMAX, IMIN, IMIN, IMAX, 1'b1));

    // limit just below the hit, then exactly at it
    set_ray(0, 0, -ONE, 0, 0, 2 * ONE, ONE / 2 - 1);
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b1));
    wait_idle();
    write_reg(REG_T_LIMIT, ONE / 2);
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b1));
    // out-of-range register index is ignored
    wait_idle();
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 1'b1));

    // extreme ray: saturating segment end and hit point
    set_ray(IMAX, IMIN, IMAX, IMAX, IMIN, IMIN, 0);
    send_triangle(noise_tri(1'b0));
    send_triangle(make_tri(IMAX, IMIN, IMAX, IMIN, IMAX, IMIN, IMAX, IMAX, IMIN, 1'b1));
    set_ray(IMIN, IMAX, IMIN, IMIN, IMAX, IMAX, IMAX);
    send_triangle(noise_tri(1'b1));

    sent = 0;
    for (int ph = 0; sent < 1530; ph++) begin
      tl = ph % 5 == 0 ? 0 : (ph % 5 == 1 ? IMAX : int'($urandom_range(0, 65535)));
      if (ph % 7 == 3) set_ray(int'($urandom), int'($urandom), int'($urandom),
                               int'($urandom), int'($urandom), int'($urandom), tl);
      else set_ray(rnd_coord(), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord(), rnd_coord(), tl);
      gaps_on = ph % 4 != 2;
      phase_len = $urandom_range(60, 140);
      for (int k = 0; k < phase_len; ) begin
        mesh_len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 5);
        for (int m = 0; m < mesh_len; m++) begin
          if ($urandom_range(0, 9) < 8) send_triangle(hit_tri(m == mesh_len - 1));
          else send_triangle(noise_tri(m == mesh_len - 1));
          k++;
          sent++;
        end
        // mid-mesh limit change is not done; stray last flags break some meshes instead
        if ($urandom_range(0, 15) == 0) send_triangle(noise_tri($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("ray_triangle_nearest_hit_core regression: pass");
    end else begin
      $display("ray_triangle_nearest_hit_core regression: fail");
    end
    $finish;
  end

endmodule
